// File: rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned EntryW  = 16;
  localparam int unsigned RowW    = 64;
  localparam int unsigned SumW    = 50;
  localparam int unsigned MagW    = 49;
  localparam int unsigned QuotW   = 33;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned IdxW    = 2;

  typedef enum logic [IdxW-1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } reg_idx_t;

  localparam logic [RowW-1:0] Row0Reset = 64'h0000_0000_0000_0100;
  localparam logic [RowW-1:0] Row1Reset = 64'h0000_0000_0100_0000;
  localparam logic [RowW-1:0] Row2Reset = 64'h0000_0100_0000_0000;
  localparam logic [RowW-1:0] Row3Reset = 64'h0100_0000_0000_0000;

  // Per-lane divide payload: sign of the quotient and unsigned magnitudes.
  typedef struct packed {
    logic              neg;
    logic [MagW-1:0]   num;
    logic [MagW-1:0]   den;
  } div_lane_t;

  typedef struct packed {
    logic              w_zero;
  } item_ctl_t;

endpackage

// File: rtl/hpt_stream_if.sv
// ----------------------------------------------------------------------------
// hpt_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hpt_stream_if #(
  parameter int unsigned W = 96
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/hpt_mac.sv
// ----------------------------------------------------------------------------
// hpt_mac
// One column of the matrix product: three 32x16 products, registered, then
// summed with the row-3 term in the next stage.
// ----------------------------------------------------------------------------
module hpt_mac
  import hpt_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  logic signed [EntryW-1:0] m0,
  input  logic signed [EntryW-1:0] m1,
  input  logic signed [EntryW-1:0] m2,
  input  logic signed [EntryW-1:0] m3,
  output logic signed [SumW-1:0]   sum
);
  logic signed [CoordW+EntryW-1:0] p0, p1, p2;
  logic signed [EntryW-1:0]        t3;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= x * m0;
      p1 <= y * m1;
      p2 <= z * m2;
      t3 <= m3;
      sum <= SumW'(p0) + SumW'(p1) + SumW'(p2) + {{(SumW-EntryW-16){t3[EntryW-1]}}, t3, 16'd0};
    end
  end
endmodule

// File: rtl/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: one quotient bit per stage, 33 stages.
// A quotient that does not fit the signed 32-bit result, that is an integer
// part of 2^15 or more in magnitude (beyond -2^15 for a negative one), saturates.
// ----------------------------------------------------------------------------
module hpt_div
  import hpt_pkg::*;
#(
  parameter int unsigned Lanes = 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  div_lane_t [Lanes-1:0]   lane_in,
  output logic [CoordW-1:0]       q   [Lanes]
);
  // Shifted-numerator form: the dividend is num * 2^16. Its upper bits seed
  // the partial remainder and the low Steps bits are brought down one per
  // stage. Quotient = floor(num * 2^16 / den), bits 32 down to 0.
  localparam int unsigned Steps = QuotW;
  localparam int unsigned RemW  = MagW + 1;

  logic [RemW-1:0]  rem [Lanes][Steps+1];
  logic [Steps-1:0] nsh [Lanes][Steps+1];
  logic [MagW-1:0]  den [Lanes][Steps+1];
  logic [QuotW-1:0] quo [Lanes][Steps+1];
  logic             neg [Lanes][Steps+1];
  logic             big [Lanes][Steps+1];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    always_comb begin
      rem[l][0] = RemW'(lane_in[l].num[MagW-1:17]);
      nsh[l][0] = {lane_in[l].num[16:0], 16'd0};
      den[l][0] = lane_in[l].den;
      quo[l][0] = '0;
      neg[l][0] = lane_in[l].neg;
      // If the upper part alone reaches the divisor, the quotient needs more
      // than Steps bits and the result saturates.
      big[l][0] = MagW'(lane_in[l].num[MagW-1:17]) >= lane_in[l].den;
    end
    for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemW-1:0] tr;
      logic [RemW-1:0] dif;
      always_comb begin
        tr  = {rem[l][s][RemW-2:0], nsh[l][s][Steps-1]};
        dif = tr - RemW'(den[l][s]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][s+1] <= dif[RemW-1] ? tr : dif;
          quo[l][s+1] <= {quo[l][s][QuotW-2:0], ~dif[RemW-1]};
          nsh[l][s+1] <= {nsh[l][s][Steps-2:0], 1'b0};
          den[l][s+1] <= den[l][s];
          neg[l][s+1] <= neg[l][s];
          big[l][s+1] <= big[l][s];
        end
      end
    end
    always_comb begin
      logic [QuotW:0] mag;
      mag = {1'b0, quo[l][Steps]};
      if (big[l][Steps] || mag > {1'b0, 33'h0_FFFF_FFFF}) mag = {2'b01, 32'd0};
      if (neg[l][Steps]) begin
        if (mag > 34'h0_8000_0000) mag = 34'h0_8000_0000;
        q[l] = CoordW'(~mag + 1'b1);
      end else begin
        if (mag > 34'h0_7FFF_FFFF) mag = 34'h0_7FFF_FFFF;
        q[l] = CoordW'(mag);
      end
    end
  end
endmodule

// File: rtl/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Transforms (x,y,z,1) by a 4x4 Q8.8 matrix and divides by w.
// ----------------------------------------------------------------------------
// Usage: points arrive on the in_ch sink channel as {pz, py, px}, 32 bits each,
// signed Q16.16. Results leave on out_ch as {w_zero, qz, qy, qx}. The matrix
// rows are written through cfg_we, cfg_idx and cfg_data while no beat is in
// flight; an index beyond row3 is ignored.
// A beat passes through the multiply and sum registers, the sign and magnitude
// register, the divide stages and one output register before its result leaves.
// Throughput is one beat per cycle while the receiver does not stall, set by the
// fully pipelined divider with one quotient bit per stage.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the whole pipeline holds; in_ch.ready falls only
// while the output register is full and not taken, so nothing is lost.
// ----------------------------------------------------------------------------
module homogeneous_point_transform
  import hpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hpt_stream_if.sink        in_ch,
  hpt_stream_if.source      out_ch,
  input  logic              cfg_we,
  input  logic [IdxW-1:0]   cfg_idx,
  input  logic [RowW-1:0]   cfg_data
);
  localparam int unsigned Depth = 2 + 1 + QuotW + 1;

  logic [RowW-1:0] row [NumRegs];
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= Row0Reset; row[1] <= Row1Reset;
      row[2] <= Row2Reset; row[3] <= Row3Reset;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_ROW0: row[0] <= cfg_data;
        REG_ROW1: row[1] <= cfg_data;
        REG_ROW2: row[2] <= cfg_data;
        REG_ROW3: row[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the last stage is empty or is taken.
  logic en;
  logic [Depth-1:0] vld;
  assign en = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  logic signed [CoordW-1:0] px, py, pz;
  assign px = in_ch.data[CoordW-1:0];
  assign py = in_ch.data[2*CoordW-1:CoordW];
  assign pz = in_ch.data[3*CoordW-1:2*CoordW];

  logic signed [SumW-1:0] s [4];
  for (genvar j = 0; j < 4; j++) begin : g_col
    hpt_mac u_mac (
      .clk(clk), .en(en), .x(px), .y(py), .z(pz),
      .m0(row[0][EntryW*j +: EntryW]), .m1(row[1][EntryW*j +: EntryW]),
      .m2(row[2][EntryW*j +: EntryW]), .m3(row[3][EntryW*j +: EntryW]),
      .sum(s[j]));
  end

  // Sign and magnitude stage.
  div_lane_t [2:0] lane;
  logic wz [QuotW+1];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lane[j].neg <= s[j][SumW-1] ^ s[3][SumW-1];
        lane[j].num <= MagW'(s[j][SumW-1] ? -s[j] : s[j]);
        lane[j].den <= (s[3] == '0) ? MagW'(1) : MagW'(s[3][SumW-1] ? -s[3] : s[3]);
      end
      wz[0] <= (s[3] == '0);
    end
  end
  for (genvar k = 0; k < QuotW; k++) begin : g_wz
    always_ff @(posedge clk) if (en) wz[k+1] <= wz[k];
  end

  logic [CoordW-1:0] q [3];
  hpt_div #(.Lanes(3)) u_div (.clk(clk), .en(en), .lane_in(lane), .q(q));

  logic [3*CoordW:0] out_r;
  always_ff @(posedge clk) begin
    if (en) out_r <= wz[QuotW] ? {1'b1, {(3*CoordW){1'b0}}} : {1'b0, q[2], q[1], q[0]};
  end
  assign out_ch.valid = vld[Depth-1];
  assign out_ch.data  = out_r;

`ifndef NO_ASSERTIONS
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data[3*CoordW] |-> out_ch.data[3*CoordW-1:0] == '0)
    else $error("w_zero result carries nonzero coordinates");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
`endif
endmodule
